// File: rtl/dne_pkg.sv
// ----------------------------------------------------------------------------
// dne_pkg
// Shared types and constants of the directional nearest element unit.
// ----------------------------------------------------------------------------
package dne_pkg;

    localparam int ELEMENT_COUNT = 16;
    localparam int IDX_W         = 4;
    localparam int POS_W         = 16;
    localparam int LIMIT_W       = 20;
    localparam int SCORE_W       = 20;
    localparam int CFG_AW        = 1;
    localparam int MEM_AW        = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int SPAN          = (ELEMENT_COUNT < 16) ? ELEMENT_COUNT : 16;
    localparam int SCAN_W        = (SPAN > 1) ? $clog2(SPAN) : 1;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_WEST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_HORIZONTAL = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_VERTICAL   = 1'b1;

    localparam logic [LIMIT_W-1:0] HORIZONTAL_RESET = 20'd10000;
    localparam logic [LIMIT_W-1:0] VERTICAL_RESET   = 20'd1000;

    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        element_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [1:0]              direction;
    } dne_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] nearest_index;
        logic             found;
    } dne_result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } dne_pos_t;

    typedef struct packed {
        logic             init;
        logic             load_origin;
        logic             entry_valid;
        logic [IDX_W-1:0] entry_index;
    } dne_scan_ctrl_t;

endpackage

// File: rtl/dne_pos_mem.sv
// ----------------------------------------------------------------------------
// dne_pos_mem
// Position table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dne_pos_mem
    import dne_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [MEM_AW-1:0] wr_addr,
    input  dne_pos_t          wr_data,
    input  logic [MEM_AW-1:0] rd_addr,
    output dne_pos_t          rd_data
);

    dne_pos_t mem [ELEMENT_COUNT];
    dne_pos_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/dne_score_unit.sv
// ----------------------------------------------------------------------------
// dne_score_unit
// Three-stage scorer: distances, weighted score, running best compare.
// ----------------------------------------------------------------------------
module dne_score_unit
    import dne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dne_scan_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]   query_index,
    input  logic [1:0]         query_direction,
    input  logic [LIMIT_W-1:0] query_bound,
    input  dne_pos_t           entry,
    output logic [IDX_W-1:0]   best_index,
    output logic               found
);

    logic [1:0]         dir_reg;
    logic [IDX_W-1:0]   qidx_reg;
    dne_pos_t           origin_reg;

    logic               s1_valid_reg;
    logic [POS_W-1:0]   s1_main_reg;
    logic [POS_W-1:0]   s1_cross_reg;
    logic [IDX_W-1:0]   s1_index_reg;

    logic               s2_valid_reg;
    logic [SCORE_W-1:0] s2_score_reg;
    logic [IDX_W-1:0]   s2_index_reg;

    logic [SCORE_W-1:0] bound_reg;
    logic [IDX_W-1:0]   best_reg;
    logic               found_reg;

    logic signed [POS_W:0] dx_fwd;
    logic signed [POS_W:0] dx_rev;
    logic signed [POS_W:0] dy_fwd;
    logic signed [POS_W:0] dy_rev;
    logic signed [POS_W:0] main_d;
    logic signed [POS_W:0] cross_d;
    logic                  ahead;
    logic                  s1_valid_next;
    logic [SCORE_W-1:0]    score_next;

    always_comb
    begin
        dx_fwd = {entry.x[POS_W-1], entry.x} - {origin_reg.x[POS_W-1], origin_reg.x};
        dx_rev = {origin_reg.x[POS_W-1], origin_reg.x} - {entry.x[POS_W-1], entry.x};
        dy_fwd = {entry.y[POS_W-1], entry.y} - {origin_reg.y[POS_W-1], origin_reg.y};
        dy_rev = {origin_reg.y[POS_W-1], origin_reg.y} - {entry.y[POS_W-1], entry.y};
        case (dir_reg)
            DIR_EAST:
            begin
                main_d  = dx_fwd;
                cross_d = dy_fwd[POS_W] ? dy_rev : dy_fwd;
            end
            DIR_WEST:
            begin
                main_d  = dx_rev;
                cross_d = dy_fwd[POS_W] ? dy_rev : dy_fwd;
            end
            DIR_SOUTH:
            begin
                main_d  = dy_fwd;
                cross_d = dx_fwd[POS_W] ? dx_rev : dx_fwd;
            end
            DIR_NORTH:
            begin
                main_d  = dy_rev;
                cross_d = dx_fwd[POS_W] ? dx_rev : dx_fwd;
            end
            default:
            begin
                main_d  = dx_fwd;
                cross_d = dy_fwd;
            end
        endcase
        ahead         = !main_d[POS_W] && (main_d != '0);
        s1_valid_next = ctrl.entry_valid && ahead && (ctrl.entry_index != qidx_reg);
        score_next    = {1'b0, s1_main_reg, 3'b000} + {3'b000, s1_main_reg, 1'b0}
                      + {2'b00, s1_cross_reg, 2'b00} + {4'b0000, s1_cross_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next && !ctrl.init;
            s2_valid_reg <= s1_valid_reg && !ctrl.init;
            if (ctrl.init)
            begin
                found_reg <= 1'b0;
            end
            else if (s2_valid_reg && (s2_score_reg < bound_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            dir_reg   <= query_direction;
            qidx_reg  <= query_index;
            bound_reg <= query_bound;
            best_reg  <= query_index;
        end
        else if (s2_valid_reg && (s2_score_reg < bound_reg))
        begin
            bound_reg <= s2_score_reg;
            best_reg  <= s2_index_reg;
        end
        if (ctrl.load_origin)
        begin
            origin_reg <= entry;
        end
        s1_main_reg  <= main_d[POS_W-1:0];
        s1_cross_reg <= cross_d[POS_W-1:0];
        s1_index_reg <= ctrl.entry_index;
        s2_score_reg <= score_next;
        s2_index_reg <= s1_index_reg;
    end

    assign best_index = best_reg;
    assign found      = found_reg;

endmodule

// File: rtl/directional_nearest_element_unit.sv
// ----------------------------------------------------------------------------
// directional_nearest_element_unit
// Position table with a directional nearest element search.
// ----------------------------------------------------------------------------
// Input channel: an item transfers at a rising edge with start high and busy
// low. A store item writes one table entry in that cycle and leaves busy low;
// it gives no result. A query item raises busy and scans the table.
// Output channel: result_valid strobes for one cycle with result; the
// receiver cannot stall, so the result is dropped after that cycle.
// Query sequence: S_ORIGIN loads the origin entry, S_SCAN one entry per cycle
// over the table, S_FLUSH and S_SETTLE drain the scoring pipeline, S_DONE shows
// the result; the next item transfers the cycle after S_DONE. A query from an
// index outside the table gives its result in the cycle after the transfer.
// The single table read port sets the one-entry-per-cycle scan.
// Configuration: cfg_write with cfg_addr 0 sets the horizontal limit, 1 the
// vertical limit; write only while busy is low.
// Reset: limits go to 10000 and 1000, the unit goes idle; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
module directional_nearest_element_unit
    import dne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dne_item_t          item,
    output logic               result_valid,
    output dne_result_t        result,
    input  logic               cfg_write,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [LIMIT_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ORIGIN = 6'b000010,
        S_SCAN   = 6'b000100,
        S_FLUSH  = 6'b001000,
        S_SETTLE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [SCAN_W-1:0]   scan_cnt_reg;
    logic [SCAN_W-1:0]   scan_cnt_next;
    logic [SCAN_W:0]     scan_inc;
    logic                scan_last;
    logic [LIMIT_W-1:0]  horizontal_limit_reg;
    logic [LIMIT_W-1:0]  vertical_limit_reg;

    logic                accept;
    logic                in_range;
    logic                mem_wr_en;
    logic [MEM_AW-1:0]   mem_rd_addr;
    dne_pos_t            mem_wr_data;
    dne_pos_t            mem_rd_data;
    dne_scan_ctrl_t      scan_ctrl;
    logic [LIMIT_W-1:0]  query_bound;
    logic [IDX_W-1:0]    best_index;
    logic                best_found;

    assign accept      = start && !busy;
    assign in_range    = int'(item.element_index) < ELEMENT_COUNT;
    assign mem_wr_en   = accept && (item.command == CMD_STORE) && in_range;
    assign mem_wr_data = '{x: item.pos_x, y: item.pos_y};
    assign scan_inc    = {1'b0, scan_cnt_reg} + (SCAN_W + 1)'(1);
    assign scan_last   = scan_cnt_reg == SCAN_W'(SPAN - 1);
    assign query_bound = ((item.direction == DIR_EAST) || (item.direction == DIR_WEST))
                       ? horizontal_limit_reg : vertical_limit_reg;

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        mem_rd_addr   = MEM_AW'(item.element_index);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.command == CMD_QUERY))
                begin
                    state_next = in_range ? S_ORIGIN : S_DONE;
                end
            end
            S_ORIGIN:
            begin
                mem_rd_addr   = '0;
                scan_cnt_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                mem_rd_addr   = MEM_AW'(scan_inc);
                scan_cnt_next = scan_inc[SCAN_W-1:0];
                if (scan_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizontal_limit_reg <= HORIZONTAL_RESET;
            vertical_limit_reg   <= VERTICAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_HORIZONTAL: horizontal_limit_reg <= cfg_data;
                CFG_VERTICAL:   vertical_limit_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        scan_ctrl.init        = accept && (item.command == CMD_QUERY);
        scan_ctrl.load_origin = state_reg == S_ORIGIN;
        scan_ctrl.entry_valid = state_reg == S_SCAN;
        scan_ctrl.entry_index = IDX_W'(scan_cnt_reg);
    end

    dne_pos_mem u_pos_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (MEM_AW'(item.element_index)),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dne_score_unit u_score_unit (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (scan_ctrl),
        .query_index     (item.element_index),
        .query_direction (item.direction),
        .query_bound     (query_bound),
        .entry           (mem_rd_data),
        .best_index      (best_index),
        .found           (best_found)
    );

    assign busy                 = state_reg != S_IDLE;
    assign result_valid         = state_reg == S_DONE;
    assign result.nearest_index = best_index;
    assign result.found         = best_found;

endmodule

// File: rtl/dne_checker.sv
// ----------------------------------------------------------------------------
// dne_checker
// Port-level checks of the directional nearest element unit.
// ----------------------------------------------------------------------------
module dne_checker
    import dne_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input dne_item_t   item,
    input logic        result_valid,
    input dne_result_t result
);

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result shown while idle");

    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command == CMD_STORE)) |=> (!busy && !result_valid))
        else $error("store transfer left the unit busy or gave a result");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command == CMD_QUERY)) |=> busy)
        else $error("query transfer did not raise busy");

    a_found_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found) |-> busy)
        else $error("found result outside a query");

endmodule

bind directional_nearest_element_unit dne_checker u_dne_checker (.*);

// File: verif/directional_nearest_element_checker.sv
// ----------------------------------------------------------------------------
// directional_nearest_element_checker
// Watches the item, result and configuration ports of the directional nearest
// element unit. It keeps a shadow of the position table and both axis limits,
// predicts the answer of every accepted query and compares each result
// strobe with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module directional_nearest_element_checker
    import dne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  dne_item_t          item,
    input  logic               result_valid,
    input  dne_result_t        result,
    input  logic               cfg_write,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int MAIN_WEIGHT  = 10;
    localparam int CROSS_WEIGHT = 5;
    localparam int REPORT_LIMIT = 10;

    logic [LIMIT_W-1:0] horiz_limit;
    logic [LIMIT_W-1:0] vert_limit;
    dne_pos_t           position_table [ELEMENT_COUNT];
    dne_result_t        expected_nearest [$];
    int                 mismatches;

    function automatic int distance(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic dne_result_t predict_nearest(input dne_item_t q);
        dne_result_t r;
        dne_pos_t    origin;
        dne_pos_t    cand;
        int          ahead;
        int          score;
        int          bound;
        logic        horiz;
        r.nearest_index = q.element_index;
        r.found         = 1'b0;
        if (int'(q.element_index) < ELEMENT_COUNT)
        begin
            horiz  = (q.direction == DIR_EAST) || (q.direction == DIR_WEST);
            bound  = horiz ? int'(horiz_limit) : int'(vert_limit);
            origin = position_table[q.element_index];
            for (int i = 0; i < SPAN; i++)
            begin
                if (i != int'(q.element_index))
                begin
                    cand = position_table[i];
                    case (q.direction)
                        DIR_EAST:  ahead = int'(cand.x) - int'(origin.x);
                        DIR_WEST:  ahead = int'(origin.x) - int'(cand.x);
                        DIR_SOUTH: ahead = int'(cand.y) - int'(origin.y);
                        default:   ahead = int'(origin.y) - int'(cand.y);
                    endcase
                    if (ahead > 0)
                    begin
                        score = ahead * MAIN_WEIGHT + CROSS_WEIGHT *
                                (horiz ? distance(cand.y, origin.y)
                                       : distance(cand.x, origin.x));
                        if (score < bound)
                        begin
                            bound           = score;
                            r.nearest_index = IDX_W'(i);
                            r.found         = 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dne_result_t exp;
        if (!rst_n)
        begin
            horiz_limit = HORIZONTAL_RESET;
            vert_limit  = VERTICAL_RESET;
            expected_nearest.delete();
            mismatches  = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_nearest.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: index %0d found %0b",
                                 result.nearest_index, result.found);
                    mismatches++;
                end
                else
                begin
                    exp = expected_nearest.pop_front();
                    if (result.nearest_index !== exp.nearest_index ||
                        result.found !== exp.found)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("result mismatch: expected %0d found %0b, got %0d found %0b",
                                     exp.nearest_index, exp.found,
                                     result.nearest_index, result.found);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (item.command == CMD_STORE)
                begin
                    if (int'(item.element_index) < ELEMENT_COUNT)
                        position_table[item.element_index] = '{x: item.pos_x, y: item.pos_y};
                end
                else
                begin
                    expected_nearest.push_back(predict_nearest(item));
                end
            end
            if (cfg_write)
            begin
                case (cfg_addr)
                    CFG_HORIZONTAL: horiz_limit = cfg_data;
                    CFG_VERTICAL:   vert_limit  = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count <= mismatches;
        pending    <= expected_nearest.size();
    end

endmodule

// File: verif/tb_directional_nearest_element_unit.sv
// ----------------------------------------------------------------------------
// tb_directional_nearest_element_unit
// Drives store and query commands into the directional nearest element unit:
// a directed table with extreme positions, ties and limit boundaries, then
// random phases under several axis limit settings with random idle gaps.
// The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_directional_nearest_element_unit;
    import dne_pkg::*;

    localparam int TIMEOUT_TICKS   = 5_000_000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 142;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    dne_item_t          item;
    logic               result_valid;
    dne_result_t        result;
    logic               cfg_write;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [LIMIT_W-1:0] cfg_data;
    int                 mismatch_count;
    int                 pending_count;

    directional_nearest_element_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    directional_nearest_element_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .fail_count   (mismatch_count),
        .pending      (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_TICKS);
        $display("tb_directional_nearest_element_unit: FAIL");
        $finish;
    end

    function automatic int idle_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int random_coordinate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 60) * 10 - 300;
        else if (r < 80)
            return $urandom_range(0, 4000) - 2000;
        else if (r < 90)
            case ($urandom_range(0, 3))
                0: return -32768;
                1: return 32767;
                2: return -32767;
                default: return 32766;
            endcase
        else
            return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic transfer(input dne_item_t next_item, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= next_item;
        do @(posedge clk); while (busy);
    endtask

    task automatic store_position(input int idx, input int x, input int y, input int gap);
        dne_item_t it;
        it.command       = CMD_STORE;
        it.element_index = IDX_W'(idx);
        it.pos_x         = POS_W'(x);
        it.pos_y         = POS_W'(y);
        it.direction     = 2'($urandom_range(0, 3));
        transfer(it, gap);
    endtask

    task automatic query_nearest(input int idx, input logic [1:0] dir, input int gap);
        dne_item_t it;
        it.command       = CMD_QUERY;
        it.element_index = IDX_W'(idx);
        it.pos_x         = POS_W'($urandom_range(0, 65535));
        it.pos_y         = POS_W'($urandom_range(0, 65535));
        it.direction     = dir;
        transfer(it, gap);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input logic [LIMIT_W-1:0] h, input logic [LIMIT_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= CFG_HORIZONTAL;
        cfg_data  <= h;
        @(negedge clk);
        cfg_addr  <= CFG_VERTICAL;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] h;
        logic [LIMIT_W-1:0] v;
        bit                 steady;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_write = 1'b0;
        cfg_addr  = CFG_HORIZONTAL;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        store_position(0, 0, 0, idle_gap(0));
        store_position(1, 100, 0, idle_gap(0));
        store_position(2, 100, 0, idle_gap(0));
        store_position(3, -32768, -32768, idle_gap(0));
        store_position(4, 32767, 32767, idle_gap(0));
        store_position(5, 0, 100, idle_gap(0));
        store_position(6, 0, -50, idle_gap(0));
        store_position(7, -100, 20, idle_gap(0));
        store_position(8, -100, -20, idle_gap(0));
        store_position(9, 1000, 999, idle_gap(0));
        store_position(10, -1, -1, idle_gap(0));
        store_position(11, 32767, -32768, idle_gap(0));
        store_position(12, -32768, 32767, idle_gap(0));
        store_position(13, 300, -300, idle_gap(0));
        store_position(14, -300, 300, idle_gap(0));
        store_position(15, 5, 5, idle_gap(0));
        query_nearest(0, DIR_EAST, idle_gap(0));
        query_nearest(0, DIR_WEST, idle_gap(0));
        query_nearest(0, DIR_SOUTH, idle_gap(0));
        query_nearest(0, DIR_NORTH, idle_gap(0));
        query_nearest(4, DIR_EAST, idle_gap(0));
        query_nearest(3, DIR_NORTH, idle_gap(0));
        query_nearest(3, DIR_EAST, idle_gap(0));
        query_nearest(15, DIR_SOUTH, idle_gap(0));
        query_nearest(1, DIR_WEST, idle_gap(0));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            steady = (p == 2);
            case (p)
                1: write_limits('0, '0);
                2: write_limits('1, '1);
                3: write_limits('0, '1);
                4: write_limits(LIMIT_W'($urandom_range(500, 20000)),
                                LIMIT_W'($urandom_range(500, 20000)));
                5:
                begin
                    h = LIMIT_W'($urandom());
                    v = LIMIT_W'($urandom());
                    write_limits(h, v);
                end
                default: ;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 30)
                    store_position($urandom_range(0, ELEMENT_COUNT - 1),
                                   random_coordinate(), random_coordinate(),
                                   idle_gap(steady));
                else
                    query_nearest($urandom_range(0, ELEMENT_COUNT - 1),
                                  2'($urandom_range(0, 3)), idle_gap(steady));
            end
        end

        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_directional_nearest_element_unit: PASS");
        else
            $display("tb_directional_nearest_element_unit: FAIL");
        $finish;
    end

endmodule
